// File: sv/udpdmx_pkg.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - shared definitions
// Types, codes and sizing constants used by the demux table, its cells,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package udpdmx_pkg;

  // Table sizing
  localparam int unsigned TableEntries = 16;
  localparam int unsigned SlotW        = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  // Width of the 4-bit slot fields on the channels
  localparam int unsigned SlotFieldW   = 4;
  // Common width for comparing a slot field against the entry count
  localparam int unsigned CmpW         = (CntW > SlotFieldW) ? CntW : SlotFieldW;

  localparam logic [15:0] EphemeralStart = 16'd1024;
  localparam logic [15:0] UdpHdrBytes    = 16'd8;

  typedef enum logic [1:0] {
    OpPacket     = 2'd0,
    OpConnect    = 2'd1,
    OpListen     = 2'd2,
    OpDisconnect = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoMatch = 2'd1,
    StFull    = 2'd2,
    StBadSlot = 2'd3
  } st_e;

  // One input transaction
  typedef struct packed {
    op_e         opcode;
    logic [31:0] pkt_src_ip;
    logic [31:0] pkt_dst_ip;
    logic [15:0] pkt_src_port;
    logic [15:0] pkt_dst_port;
    logic [15:0] pkt_length;
    logic [15:0] port_number;
    logic [31:0] peer_ip;
    logic [3:0]  slot_index;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    st_e         status;
    logic [3:0]  slot;
    logic [15:0] assigned_port;
    logic [15:0] payload_length;
    logic        moved;
    logic [3:0]  moved_from;
  } out_item_t;

  // Socket entry held by one cell
  typedef struct packed {
    logic [15:0] lport;
    logic [31:0] lip;
    logic [15:0] rport;
    logic [31:0] rip;
    logic        listen;
  } entry_t;

  // Write command from the table control into one cell
  typedef struct packed {
    logic   en;
    entry_t entry;
  } wr_t;

  // Lookup token that walks the cell chain
  typedef struct packed {
    logic             valid;
    logic             stop;   // short packet or already matched
    logic             hit;
    logic [SlotW-1:0] slot;
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [15:0]      length;
  } tok_t;

endpackage

// File: sv/udpdmx_if.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - channel interfaces
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface udpdmx_in_if;
  logic                 valid;
  logic                 ready;
  udpdmx_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface udpdmx_out_if;
  logic                  valid;
  logic                  ready;
  udpdmx_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/udpdmx_cell.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - table cell
// Holds one socket entry, checks the passing lookup token against it, binds
// a listening entry to the sender, and hands the token to the next cell.
// ----------------------------------------------------------------------------
module udpdmx_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [udpdmx_pkg::SlotW-1:0]   idx_i,
  input  logic [udpdmx_pkg::CntW-1:0]    count_i,
  input  udpdmx_pkg::wr_t                wr_i,
  input  udpdmx_pkg::tok_t               tok_i,
  output udpdmx_pkg::entry_t             entry_o,
  output udpdmx_pkg::tok_t               tok_o
);

  udpdmx_pkg::entry_t entry_q, entry_d;
  udpdmx_pkg::tok_t   tok_q, tok_d;
  logic               live;
  logic               local_hit;
  logic               bind_hit;
  logic               exact_hit;

  // Compare the token against this entry
  always_comb begin
    live      = udpdmx_pkg::CntW'(idx_i) < count_i;
    local_hit = (tok_i.dport == entry_q.lport) && (tok_i.dst_ip == entry_q.lip);
    bind_hit  = tok_i.valid && !tok_i.stop && live && local_hit && entry_q.listen;
    exact_hit = tok_i.valid && !tok_i.stop && live && local_hit && !entry_q.listen &&
                (tok_i.sport == entry_q.rport) && (tok_i.src_ip == entry_q.rip);

    tok_d = tok_i;
    if (bind_hit || exact_hit) begin
      tok_d.hit  = 1'b1;
      tok_d.stop = 1'b1;
      tok_d.slot = idx_i;
    end

    // table writes and listener binding never happen in the same cycle
    entry_d = entry_q;
    if (wr_i.en) begin
      entry_d = wr_i.entry;
    end else if (bind_hit) begin
      entry_d.listen = 1'b0;
      entry_d.rport  = tok_i.sport;
      entry_d.rip    = tok_i.src_ip;
    end
  end

  // Entry storage, written by the table control or by listener binding
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Token register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign entry_o = entry_q;
  assign tok_o   = tok_q;

endmodule

// File: sv/udp_socket_demux_table_unit.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - top level
// Socket table built as a chain of cells with connect, listen, disconnect
// and packet lookup operations.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction (packet, connect, listen,
//   disconnect); rsp_o returns exactly one result per request, in order.
//   host_ip_we_i/host_ip_wdata_i load the local address given to new entries;
//   write it only while no request is outstanding.
//   Connect, listen and disconnect finish in the cycle they are accepted; the
//   result passes through the holding register to the output register on rsp_o.
//   A packet lookup sends a token down the row of TableEntries cells, one
//   cell per cycle, and its result then passes through the holding register
//   to the output register; a new request is taken once the result has moved
//   to the output register.
//   Reset empties the table (entry count 0) and sets the next ephemeral
//   port to 1024; the host address resets to 0.
//   If the receiver stalls, one finished result waits in the output register
//   and one more in a holding register; a further request is then refused.
// ----------------------------------------------------------------------------
module udp_socket_demux_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  udpdmx_in_if.sink           req_i,
  udpdmx_out_if.source        rsp_o,
  input  logic                host_ip_we_i,
  input  logic [31:0]         host_ip_wdata_i
);

  localparam int unsigned N = udpdmx_pkg::TableEntries;

  logic [31:0]                   host_ip_q;
  logic [udpdmx_pkg::CntW-1:0]   count_q, count_d;
  logic [15:0]                   eph_q, eph_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  udpdmx_pkg::out_item_t         res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  udpdmx_pkg::out_item_t         out_q;

  logic                          accept;
  logic                          xfer;
  logic                          full;
  logic                          sidx_ok;
  logic [udpdmx_pkg::CntW-1:0]   last;
  logic [udpdmx_pkg::SlotW-1:0]  last_idx;
  logic [udpdmx_pkg::SlotW-1:0]  sidx;
  logic [udpdmx_pkg::SlotW-1:0]  wr_idx;
  logic                          wr_en;
  udpdmx_pkg::entry_t            wr_entry;
  udpdmx_pkg::entry_t            last_entry;
  udpdmx_pkg::out_item_t         ctrl_res;
  udpdmx_pkg::tok_t              inject;
  udpdmx_pkg::tok_t              tok_fin;

  udpdmx_pkg::tok_t              tok_in  [N];
  udpdmx_pkg::tok_t              tok_out [N];
  udpdmx_pkg::entry_t            ent     [N];
  udpdmx_pkg::wr_t               wr      [N];

  assign req_i.ready = !busy_q && !done_q;
  assign accept      = req_i.valid && req_i.ready;
  assign xfer        = done_q && (!out_valid_q || rsp_o.ready);

  // Host address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_ip_q <= '0;
    end else if (host_ip_we_i) begin
      host_ip_q <= host_ip_wdata_i;
    end
  end

  // Entry of the last live slot, for disconnect compaction
  always_comb begin
    last       = count_q - udpdmx_pkg::CntW'(1);
    last_idx   = last[udpdmx_pkg::SlotW-1:0];
    last_entry = '0;
    for (int i = 0; i < N; i++) begin
      if (udpdmx_pkg::SlotW'(i) == last_idx) begin
        last_entry = last_entry | ent[i];
      end
    end
  end

  // Table operations: connect, listen, disconnect
  always_comb begin
    full     = count_q == udpdmx_pkg::CntW'(N);
    sidx_ok  = udpdmx_pkg::CmpW'(req_i.data.slot_index) < udpdmx_pkg::CmpW'(count_q);
    sidx     = udpdmx_pkg::SlotW'(req_i.data.slot_index);
    wr_en    = 1'b0;
    wr_idx   = count_q[udpdmx_pkg::SlotW-1:0];
    wr_entry = '0;
    ctrl_res = '0;
    count_d  = count_q;
    eph_d    = eph_q;

    if (accept) begin
      unique case (req_i.data.opcode) inside
        udpdmx_pkg::OpConnect, udpdmx_pkg::OpListen: begin
          if (full) begin
            ctrl_res.status = udpdmx_pkg::StFull;
          end else begin
            wr_en         = 1'b1;
            ctrl_res.slot = udpdmx_pkg::SlotFieldW'(count_q);
            count_d       = count_q + udpdmx_pkg::CntW'(1);
            wr_entry.lip  = host_ip_q;
            if (req_i.data.opcode == udpdmx_pkg::OpConnect) begin
              wr_entry.lport         = eph_q;
              wr_entry.rport         = req_i.data.port_number;
              wr_entry.rip           = req_i.data.peer_ip;
              wr_entry.listen        = 1'b0;
              ctrl_res.assigned_port = eph_q;
              eph_d                  = eph_q + 16'd1;
            end else begin
              wr_entry.lport         = req_i.data.port_number;
              wr_entry.listen        = 1'b1;
              ctrl_res.assigned_port = req_i.data.port_number;
            end
          end
        end
        udpdmx_pkg::OpDisconnect: begin
          if (!sidx_ok) begin
            ctrl_res.status = udpdmx_pkg::StBadSlot;
          end else begin
            ctrl_res.slot = req_i.data.slot_index;
            count_d       = last;
            if (sidx != last_idx) begin
              wr_en               = 1'b1;
              wr_idx              = sidx;
              wr_entry            = last_entry;
              ctrl_res.moved      = 1'b1;
              ctrl_res.moved_from = udpdmx_pkg::SlotFieldW'(last);
            end
          end
        end
        default: begin
          // packet lookup runs in the cell chain
        end
      endcase
    end
  end

  // Token injected into the first cell for a packet lookup
  always_comb begin
    inject          = '0;
    inject.valid    = accept && (req_i.data.opcode == udpdmx_pkg::OpPacket);
    inject.stop     = req_i.data.pkt_length < udpdmx_pkg::UdpHdrBytes;
    inject.src_ip   = req_i.data.pkt_src_ip;
    inject.dst_ip   = req_i.data.pkt_dst_ip;
    inject.sport    = req_i.data.pkt_src_port;
    inject.dport    = req_i.data.pkt_dst_port;
    inject.length   = req_i.data.pkt_length;
  end

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = inject;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end

    assign wr[i].en    = wr_en && (wr_idx == udpdmx_pkg::SlotW'(i));
    assign wr[i].entry = wr_entry;

    udpdmx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (udpdmx_pkg::SlotW'(i)),
      .count_i (count_q),
      .wr_i    (wr[i]),
      .tok_i   (tok_in[i]),
      .entry_o (ent[i]),
      .tok_o   (tok_out[i])
    );
  end

  assign tok_fin = tok_out[N-1];

  // Result holding stage and busy tracking
  always_comb begin
    busy_d = busy_q;
    done_d = done_q && !xfer;
    res_d  = res_q;

    if (accept) begin
      if (req_i.data.opcode == udpdmx_pkg::OpPacket) begin
        busy_d = 1'b1;
      end else begin
        done_d = 1'b1;
        res_d  = ctrl_res;
      end
    end

    if (tok_fin.valid) begin
      busy_d = 1'b0;
      done_d = 1'b1;
      res_d  = '0;
      if (tok_fin.hit) begin
        res_d.status         = udpdmx_pkg::StOk;
        res_d.slot           = udpdmx_pkg::SlotFieldW'(tok_fin.slot);
        res_d.payload_length = tok_fin.length - udpdmx_pkg::UdpHdrBytes;
      end else begin
        res_d.status = udpdmx_pkg::StNoMatch;
      end
    end

    out_valid_d = (out_valid_q && !rsp_o.ready) || xfer;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      eph_q       <= udpdmx_pkg::EphemeralStart;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      eph_q       <= eph_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (xfer) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// File: sv/udpdmx_chk.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - port checker
// Watches the top-level ports and flags results or handshakes that the
// table logic can never produce.
// ----------------------------------------------------------------------------
module udpdmx_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input udpdmx_pkg::out_item_t rsp_data_i
);

  // Taking a transaction drops ready, so requests are never taken back to back
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while previous one is in progress");

  // moved_from only carries a value when an entry was moved
  a_moved_from: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_data_i.moved) |-> (rsp_data_i.moved_from == '0))
    else $error("moved_from set without a move");

  // Failed operations report no slot, port, length or move
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_data_i.status != udpdmx_pkg::StOk)) |->
      ((rsp_data_i.assigned_port == '0) && (rsp_data_i.payload_length == '0) &&
       !rsp_data_i.moved && (rsp_data_i.slot == '0)))
    else $error("failed result carries data");

  // A stalled result stays presented
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_data_i)))
    else $error("stalled result dropped or changed");

endmodule

bind udp_socket_demux_table_unit udpdmx_chk u_udpdmx_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: test/udpdmx_table_checker.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - transaction checker
// Watches the request, response and host address ports of the demux table,
// keeps its own copy of the socket table, predicts every response and
// compares each returned transaction field by field, in order.
// ----------------------------------------------------------------------------
module udpdmx_table_checker
  import udpdmx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  udpdmx_in_if        req_i,
  udpdmx_out_if       rsp_i,
  input  logic        host_ip_we_i,
  input  logic [31:0] host_ip_wdata_i,
  output int          pending_o,
  output int          fail_count_o
);

  // Shadow socket table and counters
  entry_t      sock_tab [TableEntries];
  int          live_cnt;
  logic [15:0] eph_port;
  logic [31:0] host_addr;
  int          failures;

  // Responses predicted but not yet returned, oldest first
  out_item_t   pending_rsp_q [$];

  // Apply one request to the shadow table and return the response it earns
  function automatic out_item_t demux_predict(input in_item_t rq);
    out_item_t res;
    int        idx;
    int        last;
    bit        done;
    bit        local_hit;
    res        = '0;
    res.status = StOk;
    case (rq.opcode)
      OpPacket: begin
        res.status = StNoMatch;
        if (rq.pkt_length >= UdpHdrBytes) begin
          idx  = 0;
          done = 1'b0;
          // The lowest slot that is a listener on the destination or a full match wins
          while (!done && idx < live_cnt) begin
            local_hit = sock_tab[idx].lport == rq.pkt_dst_port &&
                        sock_tab[idx].lip == rq.pkt_dst_ip;
            if (local_hit && sock_tab[idx].listen) begin
              sock_tab[idx].listen = 1'b0;
              sock_tab[idx].rport  = rq.pkt_src_port;
              sock_tab[idx].rip    = rq.pkt_src_ip;
              done = 1'b1;
            end else if (local_hit && sock_tab[idx].rport == rq.pkt_src_port &&
                         sock_tab[idx].rip == rq.pkt_src_ip) begin
              done = 1'b1;
            end
            if (done) begin
              res.status         = StOk;
              res.slot           = 4'(idx);
              res.payload_length = rq.pkt_length - UdpHdrBytes;
            end else begin
              idx++;
            end
          end
        end
      end
      OpConnect, OpListen: begin
        if (live_cnt >= TableEntries) begin
          res.status = StFull;
        end else begin
          res.slot = 4'(live_cnt);
          sock_tab[live_cnt].lip = host_addr;
          if (rq.opcode == OpConnect) begin
            res.assigned_port         = eph_port;
            sock_tab[live_cnt].lport  = eph_port;
            sock_tab[live_cnt].rport  = rq.port_number;
            sock_tab[live_cnt].rip    = rq.peer_ip;
            sock_tab[live_cnt].listen = 1'b0;
            eph_port = eph_port + 16'd1;
          end else begin
            res.assigned_port         = rq.port_number;
            sock_tab[live_cnt].lport  = rq.port_number;
            sock_tab[live_cnt].rport  = '0;
            sock_tab[live_cnt].rip    = '0;
            sock_tab[live_cnt].listen = 1'b1;
          end
          live_cnt++;
        end
      end
      default: begin
        // Disconnect: last entry fills the hole
        if (int'(rq.slot_index) >= live_cnt) begin
          res.status = StBadSlot;
        end else begin
          last     = live_cnt - 1;
          res.slot = rq.slot_index;
          if (int'(rq.slot_index) != last) begin
            sock_tab[rq.slot_index] = sock_tab[last];
            res.moved      = 1'b1;
            res.moved_from = 4'(last);
          end
          live_cnt = last;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void match_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  // Track config writes, predict on request, compare on response
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) sock_tab[i] = '0;
      live_cnt  = 0;
      eph_port  = EphemeralStart;
      host_addr = '0;
      failures  = 0;
      pending_rsp_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (host_ip_we_i) host_addr = host_ip_wdata_i;
      if (req_i.valid && req_i.ready) pending_rsp_q.push_back(demux_predict(req_i.data));
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_rsp_q.size() == 0) begin
          failures++;
          $display("%0t: response with none expected, expected none actual status %0d slot %0d",
                   $time, rsp_i.data.status, rsp_i.data.slot);
        end else begin
          want = pending_rsp_q.pop_front();
          match_field("status", want.status, rsp_i.data.status);
          match_field("slot", want.slot, rsp_i.data.slot);
          match_field("assigned_port", want.assigned_port, rsp_i.data.assigned_port);
          match_field("payload_length", want.payload_length, rsp_i.data.payload_length);
          match_field("moved", want.moved, rsp_i.data.moved);
          match_field("moved_from", want.moved_from, rsp_i.data.moved_from);
        end
      end
      pending_o    <= pending_rsp_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

// File: test/tb_udp_socket_demux_table_unit.sv
// ----------------------------------------------------------------------------
// UDP socket demux table - testbench top
// Drives connect, listen, disconnect and packet transactions into the demux
// table with random gaps and response stalls, churns connect/disconnect
// pairs back to back, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_udp_socket_demux_table_unit;
  import udpdmx_pkg::*;

  localparam int NumPhases  = 10;
  localparam int PhaseItems = 110;
  localparam int ChurnPairs = 8;
  localparam int LongHold   = 120;
  localparam int CycleLimit = 400000;

  // Traffic mix per phase
  localparam int FillMode  = 0;
  localparam int MixMode   = 1;
  localparam int DrainMode = 2;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        host_we;
  logic [31:0] host_wdata;
  int          pending;
  int          fail_count;

  udpdmx_in_if  req_if ();
  udpdmx_out_if rsp_if ();

  // Stimulus bookkeeping
  int          pace;          // idle chance in percent, 0 = back to back
  int          requests_sent;
  int          op_count [4];
  int          host_loads;
  logic [31:0] host_pool  [4];
  logic [31:0] peer_pool  [4];
  logic [15:0] rport_pool [4];
  logic [15:0] lport_pool [6];

  udp_socket_demux_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_if),
    .rsp_o           (rsp_if),
    .host_ip_we_i    (host_we),
    .host_ip_wdata_i (host_wdata)
  );

  udpdmx_table_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_if),
    .rsp_i           (rsp_if),
    .host_ip_we_i    (host_we),
    .host_ip_wdata_i (host_wdata),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Response side: random stall bursts, plus one long hold-off once 60 requests are sent
  initial begin : rsp_pacer
    bit held_off;
    held_off = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && requests_sent >= 60) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (pace != 0 && $urandom_range(0, 299) < pace) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one request, return at the edge that accepts it
  task automatic send_item(input in_item_t item);
    if (pace != 0 && $urandom_range(0, 99) < pace) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
    op_count[int'(item.opcode)]++;
  endtask

  task automatic issue(input op_e op, input logic [31:0] sip, input logic [31:0] dip,
                       input logic [15:0] sport, input logic [15:0] dport,
                       input logic [15:0] len, input logic [15:0] port,
                       input logic [31:0] peer, input logic [3:0] sidx);
    in_item_t item;
    item.opcode       = op;
    item.pkt_src_ip   = sip;
    item.pkt_dst_ip   = dip;
    item.pkt_src_port = sport;
    item.pkt_dst_port = dport;
    item.pkt_length   = len;
    item.port_number  = port;
    item.peer_ip      = peer;
    item.slot_index   = sidx;
    send_item(item);
  endtask

  // Drop valid and wait until every response is back
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_host(input logic [31:0] addr);
    host_we    <= 1'b1;
    host_wdata <= addr;
    @(posedge clk_i);
    host_we    <= 1'b0;
    host_loads++;
  endtask

  // Mostly well-formed traffic drawn from small address pools so packets
  // hit live sockets; a slice of raw noise uses random bit patterns.
  function automatic in_item_t pick_request(input int mode, input logic [15:0] eph_top);
    in_item_t it;
    int       roll;
    int       p_pkt;
    int       p_con;
    int       p_lis;
    it.opcode       = op_e'($urandom_range(0, 3));
    it.pkt_src_ip   = $urandom;
    it.pkt_dst_ip   = $urandom;
    it.pkt_src_port = 16'($urandom);
    it.pkt_dst_port = 16'($urandom);
    it.pkt_length   = 16'($urandom);
    it.port_number  = 16'($urandom);
    it.peer_ip      = $urandom;
    it.slot_index   = 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 8) return it;
    case (mode)
      FillMode:  begin p_pkt = 30; p_con = 65; p_lis = 95; end
      DrainMode: begin p_pkt = 35; p_con = 40; p_lis = 45; end
      default:   begin p_pkt = 50; p_con = 68; p_lis = 82; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < p_pkt) begin
      it.opcode       = OpPacket;
      it.pkt_src_ip   = peer_pool[$urandom_range(0, 3)];
      it.pkt_src_port = rport_pool[$urandom_range(0, 3)];
      it.pkt_dst_ip   = host_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 1) == 0) it.pkt_dst_port = lport_pool[$urandom_range(0, 5)];
      else it.pkt_dst_port = eph_top - 16'($urandom_range(1, 24));
      roll = $urandom_range(0, 99);
      if (roll < 10) it.pkt_length = 16'($urandom_range(0, 7));
      else if (roll >= 15) it.pkt_length = 16'($urandom_range(8, 1500));
    end else if (roll < p_con) begin
      it.opcode      = OpConnect;
      it.port_number = rport_pool[$urandom_range(0, 3)];
      it.peer_ip     = peer_pool[$urandom_range(0, 3)];
    end else if (roll < p_lis) begin
      it.opcode      = OpListen;
      it.port_number = lport_pool[$urandom_range(0, 5)];
    end else begin
      it.opcode = OpDisconnect;
      if ($urandom_range(0, 1) == 0) it.slot_index = 4'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Main sequence
  initial begin : stimulus
    in_item_t    it;
    logic [31:0] h;
    int          mode;
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    host_we       <= 1'b0;
    host_wdata    <= '0;
    pace          = 0;
    requests_sent = 0;
    host_loads    = 0;
    foreach (op_count[i]) op_count[i] = 0;
    host_pool  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    peer_pool  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0005, $urandom};
    rport_pool = '{16'h0000, 16'hFFFF, 16'd7000, 16'($urandom)};
    lport_pool = '{16'h0000, 16'hFFFF, 16'd53, 16'd7000, 16'd1024, 16'($urandom)};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, bind, match, short packet, bad slot, removals
    h = 32'hFFFF_FFFF;
    load_host(h);
    issue(OpPacket, 32'h0A00_0005, h, 16'd7000, 16'd0, 16'd8, '0, '0, '0);
    issue(OpDisconnect, '0, '0, '0, '0, '0, '0, '0, 4'd0);
    issue(OpConnect, '0, '0, '0, '0, '0, 16'hFFFF, 32'hFFFF_FFFF, '0);
    issue(OpListen, '0, '0, '0, '0, '0, 16'h0000, '0, '0);
    issue(OpListen, '0, '0, '0, '0, '0, 16'hFFFF, '0, '0);
    issue(OpPacket, 32'h0A00_0005, h, 16'd7000, 16'd0, 16'd7, '0, '0, '0);
    issue(OpPacket, 32'h0A00_0005, h, 16'd7000, 16'd0, 16'd8, '0, '0, '0);
    issue(OpPacket, 32'h0A00_0005, h, 16'd7000, 16'd0, 16'hFFFF, '0, '0, '0);
    issue(OpPacket, 32'hFFFF_FFFF, h, 16'hFFFF, 16'd1024, 16'd100, '0, '0, '0);
    issue(OpPacket, 32'hFFFF_FFFF, h, 16'hFFFE, 16'd1024, 16'd100, '0, '0, '0);
    issue(OpPacket, '0, '0, '0, 16'hFFFF, 16'd20, '0, '0, '0);
    issue(OpDisconnect, '0, '0, '0, '0, '0, '0, '0, 4'd15);
    issue(OpDisconnect, '0, '0, '0, '0, '0, '0, '0, 4'd0);
    issue(OpPacket, '0, h, '0, 16'hFFFF, 16'd8, '0, '0, '0);
    issue(OpDisconnect, '0, '0, '0, '0, '0, '0, '0, 4'd1);
    issue(OpConnect, '0, '0, '0, '0, '0, 16'h0000, 32'h0000_0000, '0);

    // Random phases with a new host address each
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      if (ph == NumPhases - 1) begin
        // Back to back: empty the table, then a few connect/disconnect pairs
        pace = 0;
        repeat (TableEntries) begin
          it = pick_request(DrainMode, 16'(EphemeralStart + op_count[OpConnect]));
          it.opcode     = OpDisconnect;
          it.slot_index = '0;
          send_item(it);
        end
        repeat (ChurnPairs) begin
          it = pick_request(MixMode, 16'(EphemeralStart + op_count[OpConnect]));
          it.opcode = OpConnect;
          send_item(it);
          it.opcode     = OpDisconnect;
          it.slot_index = '0;
          send_item(it);
        end
        settle();
      end else begin
        case ($urandom_range(0, 2))
          0:       pace = 0;
          1:       pace = 8;
          default: pace = 25;
        endcase
      end
      load_host(host_pool[ph % 4]);
      mode = (ph == 0) ? FillMode : ph % 3;
      repeat (PhaseItems)
        send_item(pick_request(mode, 16'(EphemeralStart + op_count[OpConnect])));
    end

    settle();
    repeat (TableEntries + 8) @(posedge clk_i);
    $display("Covered %0d requests: %0d packets, %0d connects, %0d listens, %0d disconnects.",
             requests_sent, op_count[OpPacket], op_count[OpConnect], op_count[OpListen],
             op_count[OpDisconnect]);
    $display("Host address loaded %0d times; back-to-back churn; one %0d-cycle stall.",
             host_loads, LongHold);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
